// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: label");

// Implication whose consequent is checked in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: label");

`endif

// ===== hw/rtl/mfep_pkg.sv =====
package mfep_pkg;

    localparam int TICK_BITS = 32;
    localparam int VLQ_BITS  = 28;
    localparam int SUM_BITS  = ((TICK_BITS > VLQ_BITS) ? TICK_BITS : VLQ_BITS) + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    localparam logic [1:0] KIND_NOTE    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [3:0] ERR_MAGIC     = 4'd0;
    localparam logic [3:0] ERR_HDR_LEN   = 4'd1;
    localparam logic [3:0] ERR_SMPTE     = 4'd2;
    localparam logic [3:0] ERR_ZERO_PPQ  = 4'd3;
    localparam logic [3:0] ERR_TRK_MAGIC = 4'd4;
    localparam logic [3:0] ERR_PAST_END  = 4'd5;
    localparam logic [3:0] ERR_VLQ       = 4'd6;
    localparam logic [3:0] ERR_NO_STATUS = 4'd7;
    localparam logic [3:0] ERR_CUT_OFF   = 4'd8;
    localparam logic [3:0] ERR_NO_NOTES  = 4'd9;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tick;
        logic [7:0]  pitch;
        logic [3:0]  channel;
        logic [23:0] tempo_us;
        logic [7:0]  ts_numerator;
        logic [7:0]  ts_denom_pow;
        logic        ts_changed;
        logic [7:0]  program_res;
        logic        program_seen;
        logic [14:0] ticks_per_quarter;
        logic [3:0]  error_code;
    } result_t;

endpackage

// ===== hw/rtl/midi_file_event_parser.sv =====
// A result is written into the queue as its byte is accepted; its head drives the ports.
// Throughput: one byte per cycle while full is low; all parser state updates per byte.
// A four-item result queue lets bytes keep flowing while the consumer stalls; full rises
// only when that queue is full.
// Reset (rst_n, asynchronous, active low) clears the parser, the queue and sets the
// excluded channel to 9.
module midi_file_event_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] tick,
    output logic [7:0]  pitch,
    output logic [3:0]  channel,
    output logic [23:0] tempo_us,
    output logic [7:0]  ts_numerator,
    output logic [7:0]  ts_denom_pow,
    output logic        ts_changed,
    output logic [7:0]  program_res,
    output logic        program_seen,
    output logic [14:0] ticks_per_quarter,
    output logic [3:0]  error_code
);
    import mfep_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t head;

    assign accept = push && !full;

    mfep_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (accept),
        .file_byte   (file_byte),
        .last_byte   (last_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    mfep_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (head)
    );

    assign kind              = head.kind;
    assign tick              = head.tick;
    assign pitch             = head.pitch;
    assign channel           = head.channel;
    assign tempo_us          = head.tempo_us;
    assign ts_numerator      = head.ts_numerator;
    assign ts_denom_pow      = head.ts_denom_pow;
    assign ts_changed        = head.ts_changed;
    assign program_res       = head.program_res;
    assign program_seen      = head.program_seen;
    assign ticks_per_quarter = head.ticks_per_quarter;
    assign error_code        = head.error_code;

endmodule

// ===== hw/rtl/mfep_parser.sv =====
module mfep_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data,
    input  logic                in_valid,
    input  logic [7:0]          file_byte,
    input  logic                last_byte,
    output logic                res_valid,
    output mfep_pkg::result_t   res
);
    import mfep_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_HPAD, PH_THDR, PH_DELTA, PH_STATUS, PH_MTYPE,
        PH_VLEN, PH_SKIP, PH_DATA, PH_TSKIP, PH_TAIL, PH_DONE
    } phase_t;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    function automatic logic [1:0] data_need(input logic [7:0] s);
        return (s[7:4] == 4'hc || s[7:4] == 4'hd) ? 2'd1 : 2'd2;
    endfunction

    function automatic logic [7:0] hdr_magic(input logic [1:0] p);
        case (p)
            2'd0:    return 8'h4d;
            2'd1:    return 8'h54;
            2'd2:    return 8'h68;
            default: return 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] p);
        case (p)
            2'd0:    return 8'h4d;
            2'd1:    return 8'h54;
            2'd2:    return 8'h72;
            default: return 8'h6b;
        endcase
    endfunction

    function automatic logic [31:0] tick32(input logic [TICK_BITS-1:0] t);
        logic [TICK_BITS+31:0] ext;
        ext = {32'd0, t};
        return ext[31:0];
    endfunction

    phase_t                phase_reg, phase_next;
    logic [3:0]            pos_reg, pos_next;
    logic [31:0]           chunk_reg, chunk_next;
    logic [15:0]           tracks_reg, tracks_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;
    logic [TICK_BITS-1:0]  high_reg, high_next;
    logic [7:0]            run_reg, run_next;
    logic [7:0]            cur_reg, cur_next;
    logic [7:0]            fd_reg, fd_next;
    logic [VLQ_BITS-1:0]   vacc_reg, vacc_next;
    logic [2:0]            vcnt_reg, vcnt_next;
    logic [7:0]            mtype_reg, mtype_next;
    logic [23:0]           mcap_reg, mcap_next;
    logic [VLQ_BITS-1:0]   skip_reg, skip_next;
    logic [23:0]           tempo_reg, tempo_next;
    logic                  tempo_seen_reg, tempo_seen_next;
    logic [7:0]            num_reg, num_next;
    logic [7:0]            den_reg, den_next;
    logic                  sig_seen_reg, sig_seen_next;
    logic                  sig_chg_reg, sig_chg_next;
    logic [7:0]            prog_reg, prog_next;
    logic                  prog_flag_reg, prog_flag_next;
    logic [14:0]           div_reg, div_next;
    logic                  note_found_reg, note_found_next;
    logic [3:0]            excl_reg;

    logic                  err;
    logic [3:0]            err_code;
    logic                  note;
    logic                  cd, bd, td, ah, in_track;
    logic [7:0]            cd_d2;
    logic [31:0]           rem;
    logic [7:0]            s;
    logic                  have;
    logic [1:0]            need;
    logic [SUM_BITS-1:0]   sum;
    logic [7:0]            num_v, den_v;
    logic [VLQ_BITS-1:0]   vacc_sh;
    logic [15:0]           div16;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        chunk_next      = chunk_reg;
        tracks_next     = tracks_reg;
        tick_next       = tick_reg;
        high_next       = high_reg;
        run_next        = run_reg;
        cur_next        = cur_reg;
        fd_next         = fd_reg;
        vacc_next       = vacc_reg;
        vcnt_next       = vcnt_reg;
        mtype_next      = mtype_reg;
        mcap_next       = mcap_reg;
        skip_next       = skip_reg;
        tempo_next      = tempo_reg;
        tempo_seen_next = tempo_seen_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        sig_seen_next   = sig_seen_reg;
        sig_chg_next    = sig_chg_reg;
        prog_next       = prog_reg;
        prog_flag_next  = prog_flag_reg;
        div_next        = div_reg;
        note_found_next = note_found_reg;
        err      = 1'b0;
        err_code = ERR_MAGIC;
        note     = 1'b0;
        cd       = 1'b0;
        bd       = 1'b0;
        td       = 1'b0;
        ah       = 1'b0;
        in_track = 1'b0;
        cd_d2    = 8'd0;
        rem      = chunk_reg - 32'd1;
        s        = file_byte;
        have     = 1'b0;
        need     = 2'd0;
        sum      = '0;
        num_v    = 8'd0;
        den_v    = 8'd0;
        vacc_sh  = {vacc_reg[VLQ_BITS-8:0], file_byte[6:0]};
        div16    = 16'd0;
        res      = '0;
        res_valid = 1'b0;

        if (in_valid && phase_reg != PH_DONE)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg < 4'd4)
                    begin
                        if (file_byte != hdr_magic(pos_reg[1:0]))
                        begin
                            err = 1'b1;
                            err_code = ERR_MAGIC;
                        end
                    end
                    else if (pos_reg < 4'd8)
                    begin
                        chunk_next = {chunk_reg[23:0], file_byte};
                        if (pos_reg == 4'd7 && chunk_next < 32'd6)
                        begin
                            err = 1'b1;
                            err_code = ERR_HDR_LEN;
                        end
                    end
                    else if (pos_reg == 4'd10 || pos_reg == 4'd11)
                    begin
                        tracks_next = {tracks_reg[7:0], file_byte};
                    end
                    else if (pos_reg == 4'd12)
                    begin
                        if (file_byte[7])
                        begin
                            err = 1'b1;
                            err_code = ERR_SMPTE;
                        end
                        else
                        begin
                            div_next = {file_byte[6:0], 8'd0};
                        end
                    end
                    else if (pos_reg == 4'd13)
                    begin
                        div16 = {1'b0, div_reg} | {8'd0, file_byte};
                        div_next = div16[14:0];
                        if (div16 == 16'd0)
                        begin
                            err = 1'b1;
                            err_code = ERR_ZERO_PPQ;
                        end
                        else
                        begin
                            chunk_next = chunk_reg - 32'd6;
                            if (chunk_next != 32'd0)
                                phase_next = PH_HPAD;
                            else
                                ah = 1'b1;
                        end
                    end
                end
                PH_HPAD:
                begin
                    chunk_next = rem;
                    if (rem == 32'd0)
                        ah = 1'b1;
                end
                PH_THDR:
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg < 4'd4)
                    begin
                        if (file_byte != trk_magic(pos_reg[1:0]))
                        begin
                            err = 1'b1;
                            err_code = ERR_TRK_MAGIC;
                        end
                    end
                    else
                    begin
                        chunk_next = {chunk_reg[23:0], file_byte};
                        if (pos_reg == 4'd7)
                        begin
                            tick_next  = '0;
                            run_next   = 8'd0;
                            phase_next = PH_DELTA;
                            vacc_next  = '0;
                            vcnt_next  = 3'd0;
                            if (chunk_next == 32'd0)
                                td = 1'b1;
                        end
                    end
                end
                PH_TAIL:
                begin
                end
                default:
                begin
                    in_track   = 1'b1;
                    chunk_next = rem;
                    case (phase_reg)
                        PH_DELTA:
                        begin
                            vacc_next = vacc_sh;
                            vcnt_next = vcnt_reg + 3'd1;
                            if (!file_byte[7])
                            begin
                                sum = SUM_BITS'(tick_reg) + SUM_BITS'(vacc_sh);
                                if (sum > SUM_BITS'(TICK_MAX))
                                    tick_next = TICK_MAX;
                                else
                                    tick_next = sum[TICK_BITS-1:0];
                                if (tick_next > high_reg)
                                    high_next = tick_next;
                                phase_next = PH_STATUS;
                                if (rem == 32'd0)
                                begin
                                    err = 1'b1;
                                    err_code = ERR_CUT_OFF;
                                end
                            end
                            else if (vcnt_next >= 3'd4 || rem == 32'd0)
                            begin
                                err = 1'b1;
                                err_code = ERR_VLQ;
                            end
                        end
                        PH_STATUS:
                        begin
                            if (!file_byte[7])
                            begin
                                s = run_reg;
                                have = 1'b1;
                            end
                            if (have && run_reg == 8'd0)
                            begin
                                err = 1'b1;
                                err_code = ERR_NO_STATUS;
                            end
                            else
                            begin
                                cur_next = s;
                                if (s == 8'hff)
                                begin
                                    run_next = 8'd0;
                                    phase_next = PH_MTYPE;
                                    if (rem == 32'd0)
                                    begin
                                        err = 1'b1;
                                        err_code = ERR_CUT_OFF;
                                    end
                                end
                                else if (s == 8'hf0 || s == 8'hf7)
                                begin
                                    run_next = 8'd0;
                                    phase_next = PH_VLEN;
                                    vacc_next = '0;
                                    vcnt_next = 3'd0;
                                    if (rem == 32'd0)
                                    begin
                                        err = 1'b1;
                                        err_code = ERR_VLQ;
                                    end
                                end
                                else if (s >= 8'hf0)
                                begin
                                    run_next = 8'd0;
                                    if (s == 8'hf1 || s == 8'hf3)
                                        need = 2'd1;
                                    else if (s == 8'hf2)
                                        need = 2'd2;
                                    else
                                        need = 2'd0;
                                    if (32'(need) > rem)
                                    begin
                                        err = 1'b1;
                                        err_code = ERR_CUT_OFF;
                                    end
                                    else if (need == 2'd0)
                                    begin
                                        phase_next = PH_DELTA;
                                        vacc_next = '0;
                                        vcnt_next = 3'd0;
                                    end
                                    else
                                    begin
                                        skip_next = VLQ_BITS'(need);
                                        phase_next = PH_SKIP;
                                    end
                                end
                                else
                                begin
                                    run_next = s;
                                    need = data_need(s);
                                    if (have)
                                    begin
                                        fd_next = file_byte;
                                        vcnt_next = 3'(need - 2'd1);
                                    end
                                    else
                                    begin
                                        vcnt_next = 3'(need);
                                    end
                                    if (vcnt_next == 3'd0)
                                    begin
                                        cd = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_DATA;
                                        if (rem == 32'd0)
                                        begin
                                            err = 1'b1;
                                            err_code = ERR_CUT_OFF;
                                        end
                                    end
                                end
                            end
                        end
                        PH_MTYPE:
                        begin
                            mtype_next = file_byte;
                            phase_next = PH_VLEN;
                            vacc_next = '0;
                            vcnt_next = 3'd0;
                            if (rem == 32'd0)
                            begin
                                err = 1'b1;
                                err_code = ERR_VLQ;
                            end
                        end
                        PH_VLEN:
                        begin
                            vacc_next = vacc_sh;
                            vcnt_next = vcnt_reg + 3'd1;
                            if (!file_byte[7])
                            begin
                                if (32'(vacc_sh) > rem)
                                begin
                                    err = 1'b1;
                                    err_code = ERR_CUT_OFF;
                                end
                                else if (vacc_sh == '0)
                                begin
                                    bd = 1'b1;
                                end
                                else
                                begin
                                    skip_next = vacc_sh;
                                    mcap_next = 24'd0;
                                    phase_next = PH_SKIP;
                                end
                            end
                            else if (vcnt_next >= 3'd4 || rem == 32'd0)
                            begin
                                err = 1'b1;
                                err_code = ERR_VLQ;
                            end
                        end
                        PH_SKIP:
                        begin
                            if (cur_reg == 8'hff && (vacc_reg - skip_reg) < VLQ_BITS'(3))
                                mcap_next = {mcap_reg[15:0], file_byte};
                            skip_next = skip_reg - VLQ_BITS'(1);
                            if (skip_next == '0)
                                bd = 1'b1;
                        end
                        PH_DATA:
                        begin
                            need = data_need(cur_reg);
                            if (vcnt_reg == 3'(need))
                                fd_next = file_byte;
                            vcnt_next = vcnt_reg - 3'd1;
                            if (vcnt_next == 3'd0)
                            begin
                                cd = 1'b1;
                                cd_d2 = (need == 2'd2) ? file_byte : 8'd0;
                            end
                            else if (rem == 32'd0)
                            begin
                                err = 1'b1;
                                err_code = ERR_CUT_OFF;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase

            // Channel message complete: note-on and first program change.
            if (cd)
            begin
                if (cur_next[7:4] == 4'h9 && cd_d2 != 8'd0 && cur_next[3:0] != excl_reg)
                begin
                    note = 1'b1;
                    note_found_next = 1'b1;
                end
                if (cur_next[7:4] == 4'hc && cur_next[3:0] != excl_reg && !prog_flag_reg)
                begin
                    prog_next = fd_next;
                    prog_flag_next = 1'b1;
                end
                phase_next = PH_DELTA;
                vacc_next = '0;
                vcnt_next = 3'd0;
            end

            // Meta, sysex or system common data complete.
            if (bd)
            begin
                if (cur_next == 8'hff && mtype_next == 8'h51 && vacc_next == VLQ_BITS'(3))
                begin
                    if (!tempo_seen_reg || tick_next == '0)
                    begin
                        tempo_next = mcap_next;
                        tempo_seen_next = 1'b1;
                    end
                end
                if (cur_next == 8'hff && mtype_next == 8'h58 && vacc_next >= VLQ_BITS'(2))
                begin
                    if (vacc_next == VLQ_BITS'(2))
                    begin
                        num_v = mcap_next[15:8];
                        den_v = mcap_next[7:0];
                    end
                    else
                    begin
                        num_v = mcap_next[23:16];
                        den_v = mcap_next[15:8];
                    end
                    if (!sig_seen_reg || tick_next == '0)
                    begin
                        num_next = num_v;
                        den_next = den_v;
                        sig_seen_next = 1'b1;
                    end
                    else if (num_v != num_reg || den_v != den_reg)
                    begin
                        sig_chg_next = 1'b1;
                    end
                end
                if (cur_next == 8'hff && mtype_next == 8'h2f)
                begin
                    phase_next = PH_TSKIP;
                end
                else
                begin
                    phase_next = PH_DELTA;
                    vacc_next = '0;
                    vcnt_next = 3'd0;
                end
            end

            if (in_track && !err && rem == 32'd0 &&
                (phase_next == PH_TSKIP || (phase_next == PH_DELTA && vcnt_next == 3'd0)))
                td = 1'b1;

            if (td)
            begin
                tracks_next = tracks_reg - 16'd1;
                ah = 1'b1;
            end
            if (ah)
            begin
                pos_next = 4'd0;
                phase_next = (tracks_next == 16'd0) ? PH_TAIL : PH_THDR;
            end

            if (!err && last_byte)
            begin
                err = 1'b1;
                case (phase_next)
                    PH_TAIL:
                    begin
                        if (note_found_next)
                            err = 1'b0;
                        err_code = ERR_NO_NOTES;
                    end
                    PH_HDR:  err_code = ERR_MAGIC;
                    PH_HPAD: err_code = ERR_HDR_LEN;
                    PH_THDR: err_code = ERR_TRK_MAGIC;
                    default: err_code = ERR_PAST_END;
                endcase
                if (!err)
                begin
                    res_valid = 1'b1;
                    res.kind = KIND_SUMMARY;
                    res.tick = tick32(high_next);
                    res.tempo_us = tempo_next;
                    res.ts_numerator = num_next;
                    res.ts_denom_pow = den_next;
                    res.ts_changed = sig_chg_next;
                    res.program_res = prog_next;
                    res.program_seen = prog_flag_next;
                    res.ticks_per_quarter = div_next;
                    phase_next = PH_DONE;
                end
            end

            if (err)
            begin
                res_valid = 1'b1;
                res.kind = KIND_ERROR;
                res.error_code = err_code;
                phase_next = PH_DONE;
            end
            else if (note && !res_valid)
            begin
                res_valid = 1'b1;
                res.kind = KIND_NOTE;
                res.tick = tick32(tick_next);
                res.pitch = fd_next;
                res.channel = cur_next[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            pos_reg        <= 4'd0;
            chunk_reg      <= 32'd0;
            tracks_reg     <= 16'd0;
            tick_reg       <= '0;
            high_reg       <= '0;
            run_reg        <= 8'd0;
            cur_reg        <= 8'd0;
            fd_reg         <= 8'd0;
            vacc_reg       <= '0;
            vcnt_reg       <= 3'd0;
            mtype_reg      <= 8'd0;
            mcap_reg       <= 24'd0;
            skip_reg       <= '0;
            tempo_reg      <= 24'd500000;
            tempo_seen_reg <= 1'b0;
            num_reg        <= 8'd4;
            den_reg        <= 8'd2;
            sig_seen_reg   <= 1'b0;
            sig_chg_reg    <= 1'b0;
            prog_reg       <= 8'd0;
            prog_flag_reg  <= 1'b0;
            div_reg        <= 15'd0;
            note_found_reg <= 1'b0;
            excl_reg       <= 4'd9;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            chunk_reg      <= chunk_next;
            tracks_reg     <= tracks_next;
            tick_reg       <= tick_next;
            high_reg       <= high_next;
            run_reg        <= run_next;
            cur_reg        <= cur_next;
            fd_reg         <= fd_next;
            vacc_reg       <= vacc_next;
            vcnt_reg       <= vcnt_next;
            mtype_reg      <= mtype_next;
            mcap_reg       <= mcap_next;
            skip_reg       <= skip_next;
            tempo_reg      <= tempo_next;
            tempo_seen_reg <= tempo_seen_next;
            num_reg        <= num_next;
            den_reg        <= den_next;
            sig_seen_reg   <= sig_seen_next;
            sig_chg_reg    <= sig_chg_next;
            prog_reg       <= prog_next;
            prog_flag_reg  <= prog_flag_next;
            div_reg        <= div_next;
            note_found_reg <= note_found_next;
            if (cfg_wr_en)
                excl_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== hw/rtl/mfep_fifo.sv =====
module mfep_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mfep_pkg::result_t   wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                empty,
    output mfep_pkg::result_t   rd_data
);
    import mfep_pkg::*;

    result_t                mem [QDEPTH];
    logic [QPTR_BITS-1:0]   wptr_reg, rptr_reg;
    logic [QPTR_BITS:0]     count_reg;
    logic                   do_wr, do_rd;

    assign full    = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/mfep_checker.sv =====
`include "assert_macros.svh"

module mfep_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [23:0] tempo_us,
    input logic [3:0]  error_code
);
    import mfep_pkg::*;

    // The queue can never be full and empty at once.
    `ASSERT_ALWAYS(a_full_empty, clk, rst_n, !(full && empty))
    // Only the three result kinds are ever produced.
    `ASSERT_IMPLY(a_kind_legal, clk, rst_n, !empty, kind != 2'd3)
    // Fields outside a result's kind read as zero; checked here for the tempo and error code of a note.
    `ASSERT_IMPLY(a_note_clean, clk, rst_n, !empty && kind == KIND_NOTE,
        tempo_us == 24'd0 && error_code == 4'd0)
    // A waiting item that is not taken stays visible.
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty)

endmodule

bind midi_file_event_parser mfep_checker u_mfep_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .tempo_us   (tempo_us),
    .error_code (error_code)
);
